// ===== rtl/vnf_pkg.sv =====
package vnf_pkg;

    // fixed field widths
    localparam int COORD_W = 32;
    localparam int NOISE_W = 16;
    localparam int FRAC_W  = 16;
    localparam int POS_W   = 40;
    localparam int QUOT_W  = 15;

    // default octave count
    localparam int OCTAVE_COUNT_DEF = 4;

    // hash multipliers
    localparam logic [31:0] HASH_MUL_X   = 32'd374761393;
    localparam logic [31:0] HASH_MUL_Z   = 32'd668265263;
    localparam logic [31:0] HASH_MUL_MIX = 32'd1274126177;

    // output clip level, 1.0 in Q2.14
    localparam logic [QUOT_W-1:0] CLIP_MAG = 15'd16384;

    // coordinate word moving down the cell row
    typedef struct packed {
        logic                      valid;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] z;
    } t_token;

endpackage

// ===== rtl/vnf_if.sv =====
interface vnf_coord_if;
    logic                                valid;
    logic                                ready;
    logic signed [vnf_pkg::COORD_W-1:0] coord_x;
    logic signed [vnf_pkg::COORD_W-1:0] coord_z;

    modport source (output valid, output coord_x, output coord_z, input ready);
    modport sink (input valid, input coord_x, input coord_z, output ready);
endinterface

interface vnf_noise_if;
    logic                                valid;
    logic                                ready;
    logic signed [vnf_pkg::NOISE_W-1:0] noise_value;

    modport source (output valid, output noise_value, input ready);
    modport sink (input valid, input noise_value, output ready);
endinterface

// ===== rtl/vnf_cell.sv =====
module vnf_cell #(
    parameter int OCT   = 0,
    parameter int SUM_W = 20,
    parameter int WSH   = 3
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  vnf_pkg::t_token        i_tok,
    input  logic signed [SUM_W-1:0] i_sum,
    output vnf_pkg::t_token        o_tok,
    output logic signed [SUM_W-1:0] o_sum
);

    // lerp a + floor((b - a) * t / 2^16)
    function automatic logic signed [15:0] lerp(
        input logic signed [15:0] a,
        input logic signed [15:0] b,
        input logic [15:0] t
    );
        logic signed [16:0] d;
        logic signed [33:0] p;
        logic signed [17:0] s;
        begin
            d = 17'(b) - 17'(a);
            p = 34'(d) * 34'($signed({1'b0, t}));
            s = p[33:16];
            lerp = 16'(18'(a) + s);
        end
    endfunction

    // corner value from the mixed hash
    function automatic logic signed [15:0] corner(input logic [31:0] m);
        logic [31:0] f;
        begin
            f = m ^ 32'($signed(m) >>> 16);
            corner = $signed({1'b0, f[30:16]}) - 16'sd16384;
        end
    endfunction

    logic [4:0] r_vld;
    logic signed [vnf_pkg::COORD_W-1:0] r_x [0:4];
    logic signed [vnf_pkg::COORD_W-1:0] r_z [0:4];
    logic signed [SUM_W-1:0] r_sum [0:3];

    // stage a
    logic signed [vnf_pkg::POS_W-1:0] px, pz;
    logic [31:0] x0, z0;
    logic [15:0] ux, uz;
    logic [31:0] r_a_hx, r_a_hz, r_a_sqx, r_a_sqz;
    logic [15:0] r_a_ux, r_a_uz;

    assign px = vnf_pkg::POS_W'(i_tok.x) <<< OCT;
    assign pz = vnf_pkg::POS_W'(i_tok.z) <<< OCT;
    assign x0 = 32'($signed(px[39:16]));
    assign z0 = 32'($signed(pz[39:16]));
    assign ux = px[15:0];
    assign uz = pz[15:0];

    // stage b
    logic [31:0] h [0:3];
    logic [17:0] kx, kz;
    logic [49:0] ptx, ptz;
    logic [31:0] r_b_g [0:3];
    logic [15:0] r_b_tx, r_b_tz;

    assign h[0] = r_a_hx + r_a_hz;
    assign h[1] = r_a_hx + vnf_pkg::HASH_MUL_X + r_a_hz;
    assign h[2] = r_a_hx + r_a_hz + vnf_pkg::HASH_MUL_Z;
    assign h[3] = r_a_hx + vnf_pkg::HASH_MUL_X + r_a_hz + vnf_pkg::HASH_MUL_Z;
    assign kx = 18'd196608 - {1'b0, r_a_ux, 1'b0};
    assign kz = 18'd196608 - {1'b0, r_a_uz, 1'b0};
    assign ptx = 50'(r_a_sqx) * 50'(kx);
    assign ptz = 50'(r_a_sqz) * 50'(kz);

    // stage c
    logic [31:0] r_c_m [0:3];
    logic [15:0] r_c_tx, r_c_tz;

    // stage d
    logic signed [15:0] n [0:3];
    logic signed [15:0] r_d_r0, r_d_r1;
    logic [15:0] r_d_tz;

    // stage e
    logic signed [15:0] v;
    logic signed [SUM_W-1:0] r_e_sum;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n[i] = corner(r_c_m[i]);
        end
    end

    assign v = lerp(r_d_r0, r_d_r1, r_d_tz);

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_tok.valid};
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]   <= i_tok.x;
            r_z[0]   <= i_tok.z;
            r_sum[0] <= i_sum;
            for (int s = 1; s < 5; s++) begin
                r_x[s] <= r_x[s-1];
                r_z[s] <= r_z[s-1];
            end
            for (int s = 1; s < 4; s++) begin
                r_sum[s] <= r_sum[s-1];
            end
            r_a_hx  <= x0 * vnf_pkg::HASH_MUL_X;
            r_a_hz  <= z0 * vnf_pkg::HASH_MUL_Z;
            r_a_sqx <= 32'(ux) * 32'(ux);
            r_a_sqz <= 32'(uz) * 32'(uz);
            r_a_ux  <= ux;
            r_a_uz  <= uz;
            for (int i = 0; i < 4; i++) begin
                r_b_g[i] <= h[i] ^ 32'($signed(h[i]) >>> 13);
                r_c_m[i] <= r_b_g[i] * vnf_pkg::HASH_MUL_MIX;
            end
            r_b_tx  <= ptx[47:32];
            r_b_tz  <= ptz[47:32];
            r_c_tx  <= r_b_tx;
            r_c_tz  <= r_b_tz;
            r_d_r0  <= lerp(n[0], n[1], r_c_tx);
            r_d_r1  <= lerp(n[2], n[3], r_c_tx);
            r_d_tz  <= r_c_tz;
            r_e_sum <= r_sum[3] + (SUM_W'(v) <<< WSH);
        end
    end

    assign o_tok.valid = r_vld[4];
    assign o_tok.x     = r_x[4];
    assign o_tok.z     = r_z[4];
    assign o_sum       = r_e_sum;

endmodule

// ===== rtl/vnf_div.sv =====
module vnf_div #(
    parameter int OCTAVE_COUNT = vnf_pkg::OCTAVE_COUNT_DEF,
    parameter int SUM_W        = OCTAVE_COUNT + 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic signed [SUM_W-1:0] i_sum,
    output logic                    o_valid,
    output logic signed [vnf_pkg::NOISE_W-1:0] o_value
);

    localparam int QW = vnf_pkg::QUOT_W;
    // reciprocal shift wide enough that the scaled quotient is exact over the whole sum range
    localparam int SH = SUM_W + OCTAVE_COUNT;
    localparam int MW = SH + 1;
    localparam int PW = SUM_W + MW;
    localparam logic [SUM_W-1:0] HALF = SUM_W'(((64'd1 << OCTAVE_COUNT) - 64'd1) / 2);
    localparam logic [MW-1:0] RECIP =
        MW'(((64'd1 << SH) + (64'd1 << OCTAVE_COUNT) - 64'd2)
            / ((64'd1 << OCTAVE_COUNT) - 64'd1));

    logic [1:0]       r_vld;
    logic [1:0]       r_neg;
    logic [SUM_W-1:0] r_num;
    logic [PW-1:0]    r_prod;
    logic [SUM_W-1:0] mag;
    logic [QW-1:0]    quo;
    logic [QW-1:0]    qc;

    assign mag = i_sum[SUM_W-1] ? SUM_W'(-i_sum) : SUM_W'(i_sum);

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[0], i_valid};
        end
    end

    // rounding bias and sign, then reciprocal multiply
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num    <= mag + HALF;
            r_neg[0] <= i_sum[SUM_W-1];
            r_prod   <= PW'(r_num) * PW'(RECIP);
            r_neg[1] <= r_neg[0];
        end
    end

    // clip and sign
    assign quo     = r_prod[SH +: QW];
    assign qc      = (quo > vnf_pkg::CLIP_MAG) ? vnf_pkg::CLIP_MAG : quo;
    assign o_valid = r_vld[1];
    assign o_value = r_neg[1] ? -$signed({1'b0, qc}) : $signed({1'b0, qc});

endmodule

// ===== rtl/value_noise_fbm_2d.sv =====
// channel   dir  fields                       format
// i_coord   in   coord_x, coord_z             signed Q16.16, 32 bits each
// o_noise   out  noise_value                  signed Q2.14, 16 bits
//
// one word accepted per cycle while o_noise does not stall; pipeline registers:
// five stages per octave cell, two divider stages, one output register
// reset clears all valid bits; no clearing pass
// a stall on o_noise freezes the whole pipe; i_coord.ready drops only while
// a result waits in the output register and o_noise.ready is low
module value_noise_fbm_2d #(
    parameter int OCTAVE_COUNT = vnf_pkg::OCTAVE_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    vnf_coord_if.sink   i_coord,
    vnf_noise_if.source o_noise
);

    localparam int SUM_W = OCTAVE_COUNT + 16;

    logic                    en;
    vnf_pkg::t_token         tok [0:OCTAVE_COUNT];
    logic signed [SUM_W-1:0] sum [0:OCTAVE_COUNT];
    logic                    div_vld;
    logic signed [vnf_pkg::NOISE_W-1:0] div_val;
    logic                    r_out_vld;
    logic signed [vnf_pkg::NOISE_W-1:0] r_out_val;

    // pipe advance
    assign en            = !r_out_vld || o_noise.ready;
    assign i_coord.ready = en;

    assign tok[0].valid = i_coord.valid;
    assign tok[0].x     = i_coord.coord_x;
    assign tok[0].z     = i_coord.coord_z;
    assign sum[0]       = '0;

    // one cell per octave
    for (genvar o = 0; o < OCTAVE_COUNT; o++) begin : g_oct
        vnf_cell #(
            .OCT   (o),
            .SUM_W (SUM_W),
            .WSH   (OCTAVE_COUNT - 1 - o)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_tok   (tok[o]),
            .i_sum   (sum[o]),
            .o_tok   (tok[o+1]),
            .o_sum   (sum[o+1])
        );
    end

    vnf_div #(
        .OCTAVE_COUNT (OCTAVE_COUNT),
        .SUM_W        (SUM_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (tok[OCTAVE_COUNT].valid),
        .i_sum   (sum[OCTAVE_COUNT]),
        .o_valid (div_vld),
        .o_value (div_val)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= div_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_val <= div_val;
        end
    end

    assign o_noise.valid       = r_out_vld;
    assign o_noise.noise_value = r_out_val;

endmodule

// ===== rtl/vnf_checker.sv =====
module vnf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic signed [15:0] i_noise
);

    // ready follows the output register only
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready == (!i_out_valid || i_out_ready))
        else $error("input ready does not follow output stall");

    // nothing comes out right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    // result stays in range
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_noise <= 16'sd16384 && i_noise >= -16'sd16384))
        else $error("noise value out of range");

    // stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_noise))
        else $error("stalled output word changed");

endmodule

bind value_noise_fbm_2d vnf_checker u_vnf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_coord.ready),
    .i_out_valid (o_noise.valid),
    .i_out_ready (o_noise.ready),
    .i_noise     (o_noise.noise_value)
);

// ===== bench/value_noise_fbm_2d_checker.sv =====
`timescale 1ns / 1ps

module value_noise_fbm_2d_checker #(
    parameter int OCTAVE_COUNT = vnf_pkg::OCTAVE_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_coord_valid,
    input  logic        i_coord_ready,
    input  logic [31:0] i_coord_x,
    input  logic [31:0] i_coord_z,
    input  logic        i_noise_valid,
    input  logic        i_noise_ready,
    input  logic [15:0] i_noise_value,
    output int          o_fail_count,
    output int          o_pending
);

    logic [15:0] noise_expected_q[$];

    // corner value in Q.14 from the cell integers
    function automatic longint corner_hash(logic [31:0] cx, logic [31:0] cz);
        logic [31:0] h;
        logic [31:0] m;
        logic [31:0] f;
        h = cx * vnf_pkg::HASH_MUL_X + cz * vnf_pkg::HASH_MUL_Z;
        m = (h ^ 32'($signed(h) >>> 13)) * vnf_pkg::HASH_MUL_MIX;
        f = m ^ 32'($signed(m) >>> 16);
        return longint'(f[30:16]) - 16384;
    endfunction

    function automatic longint smooth_w(longint u);
        logic [63:0] sq;
        logic [63:0] k;
        sq = u * u;
        k = 64'(3 * 65536) - 64'(2 * u);
        return longint'((sq * k) >> 32);
    endfunction

    function automatic longint blend(longint a, longint b, longint t);
        return a + ((b - a) * t >>> 16);
    endfunction

    function automatic longint octave_noise(longint px, longint pz);
        longint ix;
        longint iz;
        longint tx;
        longint tz;
        logic [31:0] x0;
        logic [31:0] z0;
        longint r0;
        longint r1;
        ix = px >>> 16;
        iz = pz >>> 16;
        tx = smooth_w(px - (ix <<< 16));
        tz = smooth_w(pz - (iz <<< 16));
        x0 = ix[31:0];
        z0 = iz[31:0];
        r0 = blend(corner_hash(x0, z0), corner_hash(x0 + 1, z0), tx);
        r1 = blend(corner_hash(x0, z0 + 1), corner_hash(x0 + 1, z0 + 1), tx);
        return blend(r0, r1, tz);
    endfunction

    function automatic logic [15:0] fbm_noise(logic [31:0] x, logic [31:0] z);
        longint cx;
        longint cz;
        longint total;
        longint den;
        longint res;
        cx = longint'($signed(x));
        cz = longint'($signed(z));
        total = 0;
        den = (longint'(1) << OCTAVE_COUNT) - 1;
        for (int o = 0; o < OCTAVE_COUNT; o++)
            total += octave_noise(cx <<< o, cz <<< o) <<< (OCTAVE_COUNT - 1 - o);
        if (total >= 0) res = (total + den / 2) / den;
        else res = -((-total + den / 2) / den);
        if (res > 16384) res = 16384;
        if (res < -16384) res = -16384;
        return res[15:0];
    endfunction

    assign o_pending = noise_expected_q.size();

    // predict on coordinate words, compare on noise words
    always @(posedge i_clk) begin
        logic [15:0] exp_v;
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end else begin
            if (i_coord_valid && i_coord_ready)
                noise_expected_q.insert(noise_expected_q.size(),
                                        fbm_noise(i_coord_x, i_coord_z));
            if (i_noise_valid && i_noise_ready) begin
                if (noise_expected_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected noise word %0d", $signed(i_noise_value));
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_v = noise_expected_q.pop_front();
                    if (exp_v !== i_noise_value) begin
                        if (o_fail_count < 10)
                            $display("noise_value mismatch: expected %0d actual %0d",
                                     $signed(exp_v), $signed(i_noise_value));
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== bench/value_noise_fbm_2d_tb.sv =====
`timescale 1ns / 1ps

module value_noise_fbm_2d_tb;
    localparam int RANDOM_WORDS = 1500;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 60;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   idle_cycles = 0;
    bit   calm = 1'b0;

    vnf_coord_if coord_ch ();
    vnf_noise_if noise_ch ();

    value_noise_fbm_2d u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_coord (coord_ch.sink),
        .o_noise (noise_ch.source)
    );

    value_noise_fbm_2d_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_coord_valid (coord_ch.valid),
        .i_coord_ready (coord_ch.ready),
        .i_coord_x     (coord_ch.coord_x),
        .i_coord_z     (coord_ch.coord_z),
        .i_noise_valid (noise_ch.valid),
        .i_noise_ready (noise_ch.ready),
        .i_noise_value (noise_ch.noise_value),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        coord_ch.valid = 1'b0;
        coord_ch.coord_x = '0;
        coord_ch.coord_z = '0;
        noise_ch.ready = 1'b0;
    end

    // watchdog on cycles with no word moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (coord_ch.valid && coord_ch.ready)
            || (noise_ch.valid && noise_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("** value_noise_fbm_2d: FAILED **");
                $finish;
            end
        end
    end

    // receiver stalls in bursts
    initial begin
        int n;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 7) == 0) begin
                noise_ch.ready <= 1'b0;
                n = $urandom_range(1, 4);
                repeat (n - 1) @(negedge i_clk);
            end else begin
                noise_ch.ready <= 1'b1;
            end
        end
    end

    // valid stays high between back to back words and drops only for idling
    task automatic send_coord(logic [31:0] x, logic [31:0] z);
        int n;
        if (!calm && $urandom_range(0, 7) == 0) begin
            coord_ch.valid <= 1'b0;
            n = $urandom_range(1, 4);
            repeat (n) @(negedge i_clk);
        end
        coord_ch.valid <= 1'b1;
        coord_ch.coord_x <= x;
        coord_ch.coord_z <= z;
        do @(posedge i_clk); while (!coord_ch.ready);
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
            2: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom())};
            default: return {16'($urandom_range(0, 7) - 4), 16'($urandom())};
        endcase
    endfunction

    initial begin
        logic [31:0] edge_vals[10];
        int k;
        edge_vals = '{32'h0, 32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h00010000,
                      32'hffff0000, 32'h0000ffff, 32'h00008000, 32'hffff8000, 32'h7fff0000};
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // extremes, cell borders and negative coordinates
        for (k = 0; k < 10; k++)
            send_coord(edge_vals[k], edge_vals[(k * 3 + 1) % 10]);
        for (k = 0; k < 10; k++)
            send_coord(edge_vals[(k + 5) % 10], edge_vals[k]);

        // hold off until the pipe is empty
        coord_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);

        for (k = 0; k < RANDOM_WORDS; k++) begin
            if (k == RANDOM_WORDS - 200) calm = 1'b1;
            if (k == RANDOM_WORDS / 2) begin
                coord_ch.valid <= 1'b0;
                @(negedge i_clk);
                while (pending != 0) @(negedge i_clk);
            end
            send_coord(rand_coord(), rand_coord());
        end

        coord_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0)
            $display("** value_noise_fbm_2d: PASSED **");
        else
            $display("** value_noise_fbm_2d: FAILED **");
        $finish;
    end

endmodule
